// File: rtl/wmsp_pkg.sv
`timescale 1ns / 1ps
package wmsp_pkg;

  localparam int WINDOW_SIZE_DEF = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int HELD_MAX        = 127;

  typedef struct packed {
    logic signed [15:0] voltage_sample;
    logic signed [15:0] current_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] mean_voltage;
    logic        [15:0] std_voltage;
    logic signed [15:0] mean_current;
    logic        [15:0] std_current;
    logic               window_ready;
    logic        [6:0]  samples_held;
  } out_item_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] mean_val;
    logic        [15:0] dev_val;
  } lane_res_t;

endpackage

// File: rtl/wmsp_lane.sv
`timescale 1ns / 1ps
module wmsp_lane #(
  parameter int WINDOW_SIZE = wmsp_pkg::WINDOW_SIZE_DEF,
  parameter int SAMPLE_BITS = wmsp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  input  logic [$clog2(WINDOW_SIZE)-1:0]       slot_i,
  input  logic                                 filled_i,
  output wmsp_pkg::lane_res_t                  res_o
);
  import wmsp_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int LOG_N  = $clog2(WINDOW_SIZE + 1);
  localparam int S_W    = SB + LOG_N;
  localparam int MAG_W  = SB - 1 + LOG_N;
  localparam int Q_W    = 2 * SB - 2 + LOG_N;
  localparam int M_W    = Q_W + LOG_N;
  localparam int QT_W   = 2 * SB;
  localparam int DIV_C  = WINDOW_SIZE * (WINDOW_SIZE - 1);
  localparam int D_W    = $clog2(DIV_C + 1);
  localparam int PROD_W = 2 * SB + 2;
  localparam int SR_W   = SB + 2;
  localparam int CNT_W  = $clog2(QT_W + MAG_W + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIFF = 3'd1;
  localparam logic [2:0] ST_PROD = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_PREP = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;
  localparam logic [2:0] ST_SQRT = 3'd7;

  logic signed [SB-1:0] mem [WINDOW_SIZE];
  logic signed [SB-1:0] old_q, smp_q;
  logic                 fil_q;

  logic [2:0]             state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic signed [S_W-1:0]  s_q, s_d;
  logic [Q_W-1:0]         q_q, q_d;
  logic signed [SB:0]     dif_q, dif_d, sum_q, sum_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [MAG_W-1:0]       mag_q, mag_d, msh_q, msh_d, nsh_q, nsh_d;
  logic                   mneg_q, mneg_d;
  logic [M_W-1:0]         acc_q, acc_d;
  logic [LOG_N-1:0]       rm_q, rm_d;
  logic [SB-1:0]          mdv_q, mdv_d;
  logic [D_W-1:0]         rd_q, rd_d;
  logic [QT_W-1:0]        dq_q, dq_d;
  logic [SB-1:0]          root_q, root_d;
  logic [SR_W-1:0]        rs_q, rs_d;
  lane_res_t              res_q, res_d;

  logic signed [SB:0]     new_x, old_x;
  logic signed [S_W-1:0]  s_abs;
  logic signed [Q_W+PROD_W-1:0] prod_x;
  logic [LOG_N:0]         mt;
  logic [D_W:0]           dt;
  logic [SB+2:0]          rr, trial;
  logic [SB+1:0]          mq, mq_adj;
  logic signed [SB+1:0]   mean_full;
  logic signed [31:0]     mean32;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mem[slot_i] <= sample_i;
      old_q       <= mem[slot_i];
    end
  end

  always_comb begin
    new_x   = (SB + 1)'(smp_q);
    old_x   = fil_q ? (SB + 1)'(old_q) : '0;
    s_abs   = s_q[S_W-1] ? -s_q : s_q;
    prod_x  = (Q_W + PROD_W)'(prod_q);
    mt      = {rm_q, mdv_q[SB-1]};
    dt      = {rd_q, dq_q[QT_W-1]};
    rr      = {rs_q[SB:0], dq_q[QT_W-1 -: 2]};
    trial   = (SB + 3)'({root_q, 2'b01});
    mq      = (SB + 2)'(mdv_q);
    mq_adj  = mq + (SB + 2)'(rm_q != '0);
    mean_full = mneg_q ? -$signed(mq_adj) : $signed(mq);
    mean32  = 32'(mean_full);
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    s_d     = s_q;
    q_d     = q_q;
    dif_d   = dif_q;
    sum_d   = sum_q;
    prod_d  = prod_q;
    mag_d   = mag_q;
    mneg_d  = mneg_q;
    msh_d   = msh_q;
    nsh_d   = nsh_q;
    acc_d   = acc_q;
    rm_d    = rm_q;
    mdv_d   = mdv_q;
    rd_d    = rd_q;
    dq_d    = dq_q;
    root_d  = root_q;
    rs_d    = rs_q;
    res_d   = res_q;
    res_d.done = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        dif_d   = new_x - old_x;
        sum_d   = new_x + old_x;
        s_d     = s_q + S_W'(new_x - old_x);
        state_d = ST_PROD;
      end
      ST_PROD: begin
        prod_d  = PROD_W'(dif_q) * PROD_W'(sum_q);
        mag_d   = MAG_W'($unsigned(s_abs));
        mneg_d  = s_q[S_W-1];
        state_d = ST_ACC;
      end
      ST_ACC: begin
        q_d     = q_q + prod_x[Q_W-1:0];
        msh_d   = mag_q;
        nsh_d   = MAG_W'(WINDOW_SIZE);
        acc_d   = '0;
        rm_d    = LOG_N'(mag_q >> SB);
        mdv_d   = mag_q[SB-1:0];
        cnt_d   = '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        acc_d = {acc_q[M_W-2:0], 1'b0}
              + (nsh_q[MAG_W-1] ? M_W'(q_q) : '0)
              - (msh_q[MAG_W-1] ? M_W'(mag_q) : '0);
        msh_d = {msh_q[MAG_W-2:0], 1'b0};
        nsh_d = {nsh_q[MAG_W-2:0], 1'b0};
        if (cnt_q < CNT_W'(SB)) begin
          if (mt >= (LOG_N + 1)'(WINDOW_SIZE)) begin
            rm_d  = LOG_N'(mt - (LOG_N + 1)'(WINDOW_SIZE));
            mdv_d = {mdv_q[SB-2:0], 1'b1};
          end else begin
            rm_d  = LOG_N'(mt);
            mdv_d = {mdv_q[SB-2:0], 1'b0};
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MAG_W - 1)) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        rd_d    = D_W'(acc_q >> QT_W);
        dq_d    = acc_q[QT_W-1:0];
        root_d  = '0;
        rs_d    = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (dt >= (D_W + 1)'(DIV_C)) begin
          rd_d = D_W'(dt - (D_W + 1)'(DIV_C));
          dq_d = {dq_q[QT_W-2:0], 1'b1};
        end else begin
          rd_d = D_W'(dt);
          dq_d = {dq_q[QT_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(QT_W - 1)) begin
          cnt_d   = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        dq_d = {dq_q[QT_W-3:0], 2'b00};
        if (rr >= trial) begin
          rs_d   = SR_W'(rr - trial);
          root_d = {root_q[SB-2:0], 1'b1};
        end else begin
          rs_d   = SR_W'(rr);
          root_d = {root_q[SB-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SB - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (state_q == ST_SQRT && cnt_q == CNT_W'(SB - 1)) begin
      res_d.done = 1'b1;
      if (mean32 > 32'sd32767) begin
        res_d.mean_val = 16'sh7FFF;
      end else if (mean32 < -32'sd32768) begin
        res_d.mean_val = 16'sh8000;
      end else begin
        res_d.mean_val = mean32[15:0];
      end
      if (32'({root_q[SB-2:0], rr >= trial}) > 32'd65535) begin
        res_d.dev_val = 16'hFFFF;
      end else begin
        res_d.dev_val = 16'({root_q[SB-2:0], rr >= trial});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      s_q     <= '0;
      q_q     <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      s_q     <= s_d;
      q_q     <= q_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == ST_IDLE) begin
      smp_q <= sample_i;
      fil_q <= filled_i;
    end
    dif_q  <= dif_d;
    sum_q  <= sum_d;
    prod_q <= prod_d;
    mag_q  <= mag_d;
    mneg_q <= mneg_d;
    msh_q  <= msh_d;
    nsh_q  <= nsh_d;
    acc_q  <= acc_d;
    rm_q   <= rm_d;
    mdv_q  <= mdv_d;
    rd_q   <= rd_d;
    dq_q   <= dq_d;
    root_q <= root_d;
    rs_q   <= rs_d;
  end

  assign res_o = res_q;

endmodule

// File: rtl/windowed_mean_stddev_pair.sv
`timescale 1ns / 1ps
// One item is in work at a time; the next can be taken as soon as the result is registered at the output.
// The two lanes shift a running-sum multiply, a restoring divide and a square root one bit a cycle.
// Reset clears the running sums, write slot, fill flag and all valid flags at once.
// Window entries are not cleared; an entry's old value is used only after it has been written.
module windowed_mean_stddev_pair #(
  parameter int WINDOW_SIZE = wmsp_pkg::WINDOW_SIZE_DEF,
  parameter int SAMPLE_BITS = wmsp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wmsp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wmsp_pkg::out_item_t out_item_o
);
  import wmsp_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_SIZE);
  localparam int SMAX   = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam int SMIN   = -SMAX - 1;

  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              filled_q, filled_d;
  logic              busy_q, busy_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic                         accept, lanes_done, xfer;
  logic signed [31:0]           v32, c32, vcl, ccl;
  logic signed [SAMPLE_BITS-1:0] v_smp, c_smp;
  logic [31:0]                  held32;
  lane_res_t                    v_res, c_res;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !busy_q;
  assign lanes_done = v_res.done && c_res.done;
  assign xfer       = (pend_q || lanes_done) && (!out_valid_q || out_ready_i);

  always_comb begin
    v32 = 32'(in_item_i.voltage_sample);
    c32 = 32'(in_item_i.current_sample);
    vcl = (v32 > SMAX) ? SMAX : ((v32 < SMIN) ? SMIN : v32);
    ccl = (c32 > SMAX) ? SMAX : ((c32 < SMIN) ? SMIN : c32);
    v_smp = vcl[SAMPLE_BITS-1:0];
    c_smp = ccl[SAMPLE_BITS-1:0];
  end

  wmsp_lane #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_volt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .sample_i (v_smp),
    .slot_i   (slot_q),
    .filled_i (filled_q),
    .res_o    (v_res)
  );

  wmsp_lane #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_curr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .sample_i (c_smp),
    .slot_i   (slot_q),
    .filled_i (filled_q),
    .res_o    (c_res)
  );

  always_comb begin
    slot_d      = slot_q;
    filled_d    = filled_q;
    busy_d      = busy_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    held32      = filled_q ? 32'(WINDOW_SIZE) : 32'(slot_q);
    if (held32 > 32'(HELD_MAX)) begin
      held32 = 32'(HELD_MAX);
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
      if ((SLOT_W + 1)'(slot_q) + 1'b1 == (SLOT_W + 1)'(WINDOW_SIZE)) begin
        slot_d   = '0;
        filled_d = 1'b1;
      end else begin
        slot_d = slot_q + 1'b1;
      end
    end
    if (lanes_done) begin
      pend_d = 1'b1;
    end
    if (xfer) begin
      pend_d             = 1'b0;
      busy_d             = 1'b0;
      out_valid_d        = 1'b1;
      out_d.mean_voltage = v_res.mean_val;
      out_d.std_voltage  = v_res.dev_val;
      out_d.mean_current = c_res.mean_val;
      out_d.std_current  = c_res.dev_val;
      out_d.window_ready = filled_q;
      out_d.samples_held = held32[6:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      filled_q    <= 1'b0;
      busy_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      slot_q      <= slot_d;
      filled_q    <= filled_d;
      busy_q      <= busy_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: rtl/wmsp_checker.sv
`timescale 1ns / 1ps
module wmsp_checker #(
  parameter int WINDOW_SIZE = wmsp_pkg::WINDOW_SIZE_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input wmsp_pkg::out_item_t out_item_o
);
  import wmsp_pkg::*;

  localparam int HELD_FULL = (WINDOW_SIZE > HELD_MAX) ? HELD_MAX : WINDOW_SIZE;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in work");

  a_held_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.samples_held != 7'd0)
    else $error("result item with no samples counted");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.window_ready |-> out_item_o.samples_held == 7'(HELD_FULL))
    else $error("full window with wrong sample count");

endmodule

bind windowed_mean_stddev_pair wmsp_checker #(
  .WINDOW_SIZE (WINDOW_SIZE)
) u_wmsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
